// ===== hw/rtl/rhh_pkg.sv =====
// ----------------------------------------------------------------------------
// rhh_pkg
// Types and constants shared by the Robin Hood hash table modules.
// ----------------------------------------------------------------------------
package rhh_pkg;

    localparam int OP_W   = 1;
    localparam int KEY_W  = 64;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int FILL_W = 7;

    localparam logic [31:0]       FNV_BASIS  = 32'd2166136261;
    localparam logic [31:0]       FNV_PRIME  = 32'd16777619;
    localparam logic [FILL_W-1:0] FILL_RESET = 7'd75;
    localparam int                PERCENT    = 100;

    localparam logic [OP_W-1:0] OP_LOOKUP = 1'b0;
    localparam logic [OP_W-1:0] OP_INSERT = 1'b1;

    typedef enum logic [ST_W-1:0] {
        ST_FOUND = 2'd0,
        ST_NEW   = 2'd1,
        ST_MISS  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_START,
        S_FREAD,
        S_FEVAL,
        S_PREAD,
        S_PEVAL,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    clr;       // write an empty slot during the clearing pass
        logic    load;      // capture an input word
        logic    hash;      // fold one key byte into the hash
        logic    probe;     // set slot index to home, zero the distance
        logic    rd;        // read the slot at the current index
        logic    adv;       // step to the next slot
        logic    upd;       // rewrite the value of the matching slot
        logic    place;     // write the carried entry, carry the old one on
        logic    cnt_inc;   // one more entry in the table
        logic    set_st;    // latch a result status
        t_status st;
        logic    take_val;  // result carries the stored value
        logic    out_load;  // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_done;
        logic hash_done;
        logic slot_valid;
        logic key_match;
        logic d_gt;
        logic n_last;
        logic full;
        logic c_gt;
        logic is_insert;
        logic out_free;
    } t_stat;

endpackage

// ===== hw/rtl/rhh_if.sv =====
// ----------------------------------------------------------------------------
// rhh_req_if / rhh_rsp_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface rhh_req_if;
    import rhh_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;

    modport source (output valid, op, key, value, input ready);
    modport sink   (input valid, op, key, value, output ready);
endinterface

interface rhh_rsp_if;
    import rhh_pkg::*;

    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] value_out;

    modport source (output valid, status, value_out, input ready);
    modport sink   (input valid, status, value_out, output ready);
endinterface

// ===== hw/rtl/rhh_ctrl.sv =====
// ----------------------------------------------------------------------------
// rhh_ctrl
// Sequencer: clearing pass, hashing, find walk, Robin Hood placement walk.
// ----------------------------------------------------------------------------
module rhh_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  rhh_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output rhh_pkg::t_cmd  o_cmd
);
    import rhh_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_stat.clr_done) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_HASH;
            S_HASH:  if (i_stat.hash_done) n_state = S_START;
            S_START: n_state = S_FREAD;
            S_FREAD: n_state = S_FEVAL;
            S_FEVAL: begin
                priority if (!i_stat.slot_valid || i_stat.d_gt) begin
                    n_state = (i_stat.is_insert && !i_stat.full) ? S_PREAD : S_DONE;
                end else if (i_stat.key_match) begin
                    n_state = S_DONE;
                end else if (i_stat.n_last) begin
                    n_state = (i_stat.is_insert && !i_stat.full) ? S_PREAD : S_DONE;
                end else begin
                    n_state = S_FREAD;
                end
            end
            S_PREAD: n_state = S_PEVAL;
            S_PEVAL: n_state = i_stat.slot_valid ? S_PREAD : S_DONE;
            S_DONE:  if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.st   = ST_FOUND;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd.clr = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_HASH:  o_cmd.hash  = 1'b1;
            S_START: o_cmd.probe = 1'b1;
            S_FREAD: o_cmd.rd    = 1'b1;
            S_FEVAL: begin
                priority if (!i_stat.slot_valid || i_stat.d_gt || (!i_stat.key_match
                             && i_stat.n_last)) begin
                    // key absent
                    o_cmd.set_st = 1'b1;
                    if (!i_stat.is_insert) begin
                        o_cmd.st = ST_MISS;
                    end else if (i_stat.full) begin
                        o_cmd.st = ST_FULL;
                    end else begin
                        o_cmd.st    = ST_NEW;
                        o_cmd.probe = 1'b1;
                    end
                end else if (i_stat.key_match) begin
                    o_cmd.set_st   = 1'b1;
                    o_cmd.st       = ST_FOUND;
                    o_cmd.take_val = !i_stat.is_insert;
                    o_cmd.upd      = i_stat.is_insert;
                end else begin
                    o_cmd.adv = 1'b1;
                end
            end
            S_PREAD: o_cmd.rd = 1'b1;
            S_PEVAL: begin
                if (!i_stat.slot_valid) begin
                    o_cmd.place   = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                end else begin
                    o_cmd.place = i_stat.c_gt;
                    o_cmd.adv   = 1'b1;
                end
            end
            S_DONE: o_cmd.out_load = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== hw/rtl/rhh_datapath.sv =====
// ----------------------------------------------------------------------------
// rhh_datapath
// Slot memory, FNV-1a hash unit, probe registers, entry count, result register.
// ----------------------------------------------------------------------------
module rhh_datapath #(
    parameter int CAPACITY   = 256,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rhh_pkg::t_cmd              i_cmd,
    input  logic [rhh_pkg::OP_W-1:0]   i_op,
    input  logic [rhh_pkg::KEY_W-1:0]  i_key,
    input  logic [rhh_pkg::VAL_W-1:0]  i_value,
    input  logic                       i_cfg_we,
    input  logic [rhh_pkg::FILL_W-1:0] i_cfg_wdata,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [rhh_pkg::ST_W-1:0]   o_status,
    output logic [rhh_pkg::VAL_W-1:0]  o_value_out,
    output rhh_pkg::t_stat             o_stat
);
    import rhh_pkg::*;

    localparam int AW     = $clog2(CAPACITY);
    localparam int CW     = AW + 1;
    localparam int FW     = CW + FILL_W;
    localparam int NBYTES = (KEY_BITS + 7) / 8;
    localparam int BW     = (NBYTES > 1) ? $clog2(NBYTES) : 1;
    // slot word: {valid, key, value, distance}
    localparam int DO = 0;
    localparam int VO = AW;
    localparam int KO = AW + VALUE_BITS;
    localparam int VB = AW + VALUE_BITS + KEY_BITS;
    localparam int WW = VB + 1;

    logic [WW-1:0] mem [CAPACITY];
    logic [WW-1:0] r_rdata;
    logic [WW-1:0] n_wdata;
    logic          n_we;

    logic [OP_W-1:0]       r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [KEY_BITS-1:0]   r_kshift;
    logic [VALUE_BITS-1:0] r_value;
    logic [31:0]           r_hash;
    logic [BW-1:0]         r_bcnt;
    logic [AW-1:0]         r_idx;
    logic [AW-1:0]         r_n;
    logic [KEY_BITS-1:0]   r_ckey;
    logic [VALUE_BITS-1:0] r_cval;
    logic [AW-1:0]         r_cdist;
    logic [CW-1:0]         r_count;
    logic [FILL_W-1:0]     r_limit;
    t_status               r_st;
    logic [VAL_W-1:0]      r_rval;
    logic                  r_ovalid;
    t_status               r_ost;
    logic [VAL_W-1:0]      r_oval;

    logic [31:0]           n_mix;
    logic [31:0]           n_hash;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic [AW-1:0]         rd_dist;
    logic [FW-1:0]         load_lhs;
    logic [FW-1:0]         load_rhs;

    assign rd_key  = r_rdata[KO +: KEY_BITS];
    assign rd_val  = r_rdata[VO +: VALUE_BITS];
    assign rd_dist = r_rdata[DO +: AW];

    // h * 16777619 = h<<24 + h<<8 + h*0x93
    assign n_mix  = r_hash ^ {24'd0, r_kshift[7:0]};
    assign n_hash = (n_mix << 24) + (n_mix << 8) + (n_mix << 7) + (n_mix << 4)
                  + (n_mix << 1) + n_mix;

    assign load_lhs = FW'(r_count) * FW'(PERCENT);
    assign load_rhs = FW'(CAPACITY) * FW'(r_limit);

    always_comb begin
        n_we    = i_cmd.clr | i_cmd.upd | i_cmd.place;
        n_wdata = '0;
        priority if (i_cmd.upd) begin
            n_wdata = {1'b1, rd_key, r_value, rd_dist};
        end else if (i_cmd.place) begin
            n_wdata = {1'b1, r_ckey, r_cval, r_cdist};
        end else begin
            n_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            mem[r_idx] <= n_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_idx];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_count  <= '0;
            r_limit  <= FILL_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.clr || i_cmd.adv) begin
                r_idx <= r_idx + 1'b1;
            end else if (i_cmd.probe) begin
                r_idx <= r_hash[AW-1:0];
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_key    <= KEY_BITS'(i_key);
            r_kshift <= KEY_BITS'(i_key);
            r_value  <= VALUE_BITS'(i_value);
            r_hash   <= FNV_BASIS;
            r_bcnt   <= '0;
        end else if (i_cmd.hash) begin
            r_hash   <= n_hash;
            r_kshift <= r_kshift >> 8;
            r_bcnt   <= r_bcnt + 1'b1;
        end
        if (i_cmd.probe) begin
            r_n     <= '0;
            r_ckey  <= r_key;
            r_cval  <= r_value;
            r_cdist <= '0;
        end else begin
            if (i_cmd.adv) begin
                r_n <= r_n + 1'b1;
            end
            if (i_cmd.place && i_cmd.adv) begin
                // carry the displaced entry on
                r_ckey  <= rd_key;
                r_cval  <= rd_val;
                r_cdist <= rd_dist + 1'b1;
            end else if (i_cmd.adv) begin
                r_cdist <= r_cdist + 1'b1;
            end
        end
        if (i_cmd.set_st) begin
            r_st   <= i_cmd.st;
            r_rval <= i_cmd.take_val ? VAL_W'(rd_val) : '0;
        end
        if (i_cmd.out_load) begin
            r_ost  <= r_st;
            r_oval <= r_rval;
        end
    end

    assign o_stat.clr_done   = (r_idx == AW'(CAPACITY - 1));
    assign o_stat.hash_done  = (r_bcnt == BW'(NBYTES - 1));
    assign o_stat.slot_valid = r_rdata[VB];
    assign o_stat.key_match  = (rd_key == r_key);
    assign o_stat.d_gt       = (r_n > rd_dist);
    assign o_stat.n_last     = (r_n == AW'(CAPACITY - 1));
    assign o_stat.full       = (load_lhs >= load_rhs) || (r_count >= CW'(CAPACITY));
    assign o_stat.c_gt       = (r_cdist > rd_dist);
    assign o_stat.is_insert  = (r_op == OP_INSERT);
    assign o_stat.out_free   = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_status    = r_ost;
    assign o_value_out = r_oval;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && (r_ost != ST_FOUND) |-> (r_oval == '0))
        else $error("nonzero value on a result without a hit");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_inc |=> (r_count == $past(r_count) + 1'b1))
        else $error("entry count did not advance on placement");
`endif

endmodule

// ===== hw/rtl/robin_hood_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// robin_hood_hash_table_core
// Fixed-capacity Robin Hood hash table with FNV-1a keys, lookup and insert.
// ----------------------------------------------------------------------------
// Each request word is a lookup (op 0) or an insert/update (op 1) of a key.
// The key is hashed with 32-bit FNV-1a, one byte per cycle, least
// significant byte first; the low hash bits select the home slot. A lookup
// walks forward until it hits the key, an empty slot, or a slot whose stored
// probe distance is shorter than its own. An insert of a present key rewrites
// its value; a new key is refused with status full once entry_count*100 >=
// CAPACITY*fill_limit_percent, otherwise it is placed by the Robin Hood rule,
// swapping with richer entries on the way. The slot store is a single-port
// memory with registered reads, so each visited slot takes a read state and
// an evaluate state. A request passes through the hash state, a start state,
// the find walk, the placement walk for a new key, and the done state.
// After reset the block runs a clearing pass over the slot memory and takes no
// request until it is over; configuration writes are taken at any time. The
// result word sits in an output register, so a new request is taken while
// the previous result still waits.
// ----------------------------------------------------------------------------
module robin_hood_hash_table_core #(
    parameter int CAPACITY   = 256,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    rhh_req_if.sink                    i_req,
    rhh_rsp_if.source                  o_rsp,
    input  logic                       i_cfg_we,
    input  logic [rhh_pkg::FILL_W-1:0] i_cfg_wdata
);
    import rhh_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer: owns the request handshake
    rhh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_stat     (stat),
        .o_in_ready (i_req.ready),
        .o_cmd      (cmd)
    );

    // storage, hash and result register
    rhh_datapath #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_op        (i_req.op),
        .i_key       (i_req.key),
        .i_value     (i_req.value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_status    (o_rsp.status),
        .o_value_out (o_rsp.value_out),
        .o_stat      (stat)
    );

endmodule

// ===== verif/robin_hood_hash_table_core_test.sv =====
// ----------------------------------------------------------------------------
// robin_hood_hash_table_core_test
// Self-checking bench for the Robin Hood hash table core.
// ----------------------------------------------------------------------------
// Request words go in through a valid/ready channel. Each accepted word is run
// through a local copy of the table: FNV-1a hash, Robin Hood probing, and the
// fill limit. The expected result word is queued, and every result word taken
// from the block is matched against the oldest entry. Directed tests cover
// empty lookups, extreme keys and values, updates under a full table, fill
// limits of zero and one, and home-slot collisions with wrap-around. Random
// phases then fill the table under several fill limits.
// ----------------------------------------------------------------------------
module robin_hood_hash_table_core_test;
    import rhh_pkg::*;

    localparam int SLOTS       = 256;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        t_status          status;
        logic [VAL_W-1:0] value;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [FILL_W-1:0] i_cfg_wdata;

    rhh_req_if req ();
    rhh_rsp_if rsp ();

    robin_hood_hash_table_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_rsp       (rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Local copy of the table
    logic             tbl_valid [SLOTS];
    logic [31:0]      tbl_hash  [SLOTS];
    logic [KEY_W-1:0] tbl_key   [SLOTS];
    logic [VAL_W-1:0] tbl_value [SLOTS];
    int               tbl_dist  [SLOTS];
    int               tbl_count;
    int               fill_pct;

    t_result          pending_results[$];
    logic [KEY_W-1:0] stored_keys[$];

    int  errors;
    int  cycles;
    int  words_sent;
    int  status_seen [4];
    bit  gaps_on;
    int  burst_left;

    // Clock: period 8
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic [31:0] fnv1a_hash(logic [KEY_W-1:0] k);
        logic [31:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < KEY_W / 8; i++) begin
            h = h ^ {24'd0, k[8*i +: 8]};
            h = h * FNV_PRIME;
        end
        return h;
    endfunction

    // Walk from home; stop on an empty slot or a richer resident.
    function automatic int locate_key(logic [31:0] h, logic [KEY_W-1:0] k);
        int idx;
        idx = int'(h[7:0]);
        for (int d = 0; d < SLOTS; d++) begin
            if (!tbl_valid[idx]) return -1;
            if (d > tbl_dist[idx]) return -1;
            if (tbl_hash[idx] == h && tbl_key[idx] == k) return idx;
            idx = (idx + 1) % SLOTS;
        end
        return -1;
    endfunction

    // Carry the new entry forward, swapping with richer residents.
    function automatic void place_entry(logic [31:0] h, logic [KEY_W-1:0] k,
                                        logic [VAL_W-1:0] v);
        int               idx;
        int               c_dist;
        int               t_dist;
        logic [31:0]      c_hash, t_hash;
        logic [KEY_W-1:0] c_key, t_key;
        logic [VAL_W-1:0] c_val, t_val;
        idx = int'(h[7:0]);
        c_hash = h; c_key = k; c_val = v; c_dist = 0;
        for (int n = 0; n < SLOTS; n++) begin
            if (!tbl_valid[idx]) begin
                tbl_valid[idx] = 1'b1;
                tbl_hash[idx]  = c_hash;
                tbl_key[idx]   = c_key;
                tbl_value[idx] = c_val;
                tbl_dist[idx]  = c_dist;
                tbl_count++;
                return;
            end
            if (c_dist > tbl_dist[idx]) begin
                t_hash = tbl_hash[idx]; t_key = tbl_key[idx];
                t_val = tbl_value[idx]; t_dist = tbl_dist[idx];
                tbl_hash[idx] = c_hash; tbl_key[idx] = c_key;
                tbl_value[idx] = c_val; tbl_dist[idx] = c_dist;
                c_hash = t_hash; c_key = t_key; c_val = t_val; c_dist = t_dist;
            end
            idx = (idx + 1) % SLOTS;
            c_dist++;
        end
    endfunction

    function automatic t_result table_apply(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                                            logic [VAL_W-1:0] v);
        t_result     r;
        logic [31:0] h;
        int          at;
        h = fnv1a_hash(k);
        at = locate_key(h, k);
        r.value = '0;
        if (op == OP_LOOKUP) begin
            if (at >= 0) begin
                r.status = ST_FOUND;
                r.value  = tbl_value[at];
            end else begin
                r.status = ST_MISS;
            end
        end else if (at >= 0) begin
            tbl_value[at] = v;
            r.status = ST_FOUND;
        end else if (tbl_count * PERCENT >= SLOTS * fill_pct || tbl_count >= SLOTS) begin
            r.status = ST_FULL;
        end else begin
            place_entry(h, k, v);
            stored_keys.push_back(k);
            r.status = ST_NEW;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------
    // Send one word; open a random gap between bursts when gaps are on.
    task automatic send_word(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                             logic [VAL_W-1:0] v);
        int gap;
        @(negedge i_clk);
        if (gaps_on && burst_left == 0) begin
            req.valid = 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        req.valid = 1'b1;
        req.op    = op;
        req.key   = k;
        req.value = v;
        do @(posedge i_clk); while (!req.ready);
        pending_results.push_back(table_apply(op, k, v));
        words_sent++;
    endtask

    // Drop valid and wait until every result word is back.
    task automatic drain();
        @(negedge i_clk);
        req.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_fill_limit(logic [FILL_W-1:0] pct);
        drain();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = pct;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        fill_pct = int'(pct);
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [KEY_W-1:0] known_key();
        return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_empty_table();
        send_word(OP_LOOKUP, '0, '1);
        send_word(OP_LOOKUP, '1, '0);
    endtask

    task automatic test_extremes();
        send_word(OP_INSERT, '0, '1);
        send_word(OP_INSERT, '1, '0);
        send_word(OP_INSERT, 64'h8000_0000_0000_0001, 32'h8000_0001);
        send_word(OP_LOOKUP, '0, '0);
        send_word(OP_LOOKUP, '1, '1);
        send_word(OP_INSERT, '0, 32'h1234_5678);
        send_word(OP_LOOKUP, '0, 32'hdead_beef);
        send_word(OP_LOOKUP, 64'h8000_0000_0000_0001, '0);
    endtask

    // Fill limits of one and zero refuse new keys; updates still go through.
    task automatic test_fill_limit_low();
        write_fill_limit(7'd1);
        send_word(OP_INSERT, 64'h0123_4567_89ab_cdef, 32'h1);
        send_word(OP_INSERT, '1, 32'h5555_aaaa);
        send_word(OP_LOOKUP, '1, '0);
        write_fill_limit(7'd0);
        send_word(OP_INSERT, 64'hfedc_ba98_7654_3210, 32'h2);
        send_word(OP_INSERT, '0, 32'haaaa_5555);
        send_word(OP_LOOKUP, '0, '0);
    endtask

    // Keys sharing the last home slot: forces displacement and wrap to slot 0.
    task automatic test_collisions();
        logic [KEY_W-1:0] k;
        logic [31:0]      h;
        logic [KEY_W-1:0] group[$];
        write_fill_limit(7'd75);
        while (group.size() < 5) begin
            k = random_key();
            h = fnv1a_hash(k);
            if (h[7:0] == 8'hff) group.push_back(k);
        end
        foreach (group[i]) send_word(OP_INSERT, group[i], $urandom);
        foreach (group[i]) send_word(OP_LOOKUP, group[i], '0);
    endtask

    // Mix of new inserts, updates, hits and misses under one fill limit.
    task automatic test_random_phase(logic [FILL_W-1:0] pct, int n_words);
        int pick;
        write_fill_limit(pct);
        gaps_on = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < n_words; i++) begin
            if (i % 150 == 149) gaps_on = !gaps_on;
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_word(OP_INSERT, random_key(), $urandom);
            else if (pick < 60)
                send_word(OP_INSERT, known_key(), $urandom);
            else if (pick < 90)
                send_word(OP_LOOKUP, known_key(), $urandom);
            else
                send_word(OP_LOOKUP, random_key(), $urandom);
        end
        gaps_on = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------------
    int stall_mode;
    always @(negedge i_clk) begin
        if (cycles % 300 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       rsp.ready = 1'b1;
            1:       rsp.ready = 1'($urandom_range(0, 1));
            2:       rsp.ready = ($urandom_range(0, 7) == 0);
            default: rsp.ready = ((cycles / 5) % 2 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: status %0d value %h",
                       rsp.status, rsp.value_out);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    errors++;
                end
                if (rsp.value_out !== want.value) begin
                    $error("value_out: expected %h, got %h", want.value, rsp.value_out);
                    errors++;
                end
                status_seen[want.status]++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        errors = 0; cycles = 0; words_sent = 0; burst_left = 0; gaps_on = 1'b0;
        stall_mode = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        foreach (tbl_valid[i]) begin
            tbl_valid[i] = 1'b0; tbl_hash[i] = '0; tbl_key[i] = '0;
            tbl_value[i] = '0; tbl_dist[i] = 0;
        end
        tbl_count = 0;
        fill_pct  = int'(FILL_RESET);
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_wdata = '0;
        req.valid = 1'b0; req.op = OP_LOOKUP; req.key = '0; req.value = '0;
        rsp.ready = 1'b1;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_extremes();
        test_fill_limit_low();
        test_collisions();
        test_random_phase(7'd50, 450);
        test_random_phase(7'd75, 450);
        test_random_phase(7'd100, 450);
        test_random_phase(7'd127, 400);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("sent %0d words, table holds %0d of %0d entries", words_sent,
                 tbl_count, SLOTS);
        $display("results: %0d found, %0d new, %0d missed, %0d refused, %0d errors",
                 status_seen[ST_FOUND], status_seen[ST_NEW], status_seen[ST_MISS],
                 status_seen[ST_FULL], errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== robin_hood_hash_table_core.f =====
hw/rtl/rhh_pkg.sv
hw/rtl/rhh_if.sv
hw/rtl/rhh_ctrl.sv
hw/rtl/rhh_datapath.sv
hw/rtl/robin_hood_hash_table_core.sv
verif/robin_hood_hash_table_core_test.sv
